FILE: design/assert_macros.svh
// Assertion helpers shared by the walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

FILE: design/dtw_pkg.sv
package dtw_pkg;

  // Field widths.
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned HSIZE_W  = 3;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned VIEW_W   = 32;
  localparam int unsigned APB_W    = 32;
  localparam int unsigned ADDR_W   = 3;

  // Longest accepted long-form length, in octets.
  localparam int unsigned LENGTH_OCTETS_MAX = 3;

  // Parse phases.
  localparam logic [1:0] PH_TAG  = 2'd0;
  localparam logic [1:0] PH_LEN1 = 2'd1;
  localparam logic [1:0] PH_LENX = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  // Result status codes.
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_TRUNCATED   = 4'd1;
  localparam logic [3:0] ST_HIGH_TAG    = 4'd2;
  localparam logic [3:0] ST_INDEFINITE  = 4'd3;
  localparam logic [3:0] ST_RESERVED    = 4'd4;
  localparam logic [3:0] ST_TOO_MANY    = 4'd5;
  localparam logic [3:0] ST_NONMINIMAL  = 4'd6;
  localparam logic [3:0] ST_TOO_LARGE   = 4'd7;
  localparam logic [3:0] ST_OVERRUN     = 4'd8;
  localparam logic [3:0] ST_PAST_END    = 4'd9;

  // Register indexes (word address bit 2).
  localparam logic REG_VIEW_LENGTH = 1'b0;
  localparam logic REG_MAX_BODY    = 1'b1;

  // Identifier and length octet codes.
  localparam logic [4:0] TAG_HIGH_FORM  = 5'h1F;
  localparam logic [7:0] LEN_INDEFINITE = 8'h80;
  localparam logic [7:0] LEN_RESERVED   = 8'hFF;
  localparam logic [LEN_W-1:0] LEN_MAX_RESET = {LEN_W{1'b1}};

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              view_start;
  } dtw_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   element_tag;
    logic [HSIZE_W-1:0]  header_size;
    logic [LEN_W-1:0]    body_length;
  } dtw_result_t;

  typedef struct packed {
    logic [VIEW_W-1:0] view_length;
    logic [LEN_W-1:0]  max_body_length;
  } dtw_cfg_t;

endpackage

FILE: design/dtw_if.sv
// Byte channel into the walker.
interface dtw_in_if;
  logic                          valid;
  logic                          ready;
  logic [dtw_pkg::DATA_W-1:0]    data_byte;
  logic                          view_start;

  modport source (output valid, output data_byte, output view_start, input ready);
  modport sink   (input valid, input data_byte, input view_start, output ready);
endinterface

// Result channel out of the walker.
interface dtw_out_if;
  logic                          valid;
  logic                          ready;
  logic [dtw_pkg::STATUS_W-1:0]  status;
  logic [dtw_pkg::DATA_W-1:0]    element_tag;
  logic [dtw_pkg::HSIZE_W-1:0]   header_size;
  logic [dtw_pkg::LEN_W-1:0]     body_length;

  modport source (output valid, output status, output element_tag, output header_size,
                  output body_length, input ready);
  modport sink   (input valid, input status, input element_tag, input header_size,
                  input body_length, output ready);
endinterface

FILE: design/dtw_cfg_regs.sv
module dtw_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dtw_pkg::ADDR_W-1:0]  paddr,
  input  logic [dtw_pkg::APB_W-1:0]   pwdata,
  output logic [dtw_pkg::APB_W-1:0]   prdata,
  output logic                        pready,
  output dtw_pkg::dtw_cfg_t           cfg
);
  import dtw_pkg::*;

  logic [VIEW_W-1:0] view_length_r;
  logic [LEN_W-1:0]  max_body_r;
  logic              wr_en;
  logic              reg_idx;

  // Word index; the two low address bits select bytes and are ignored.
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_length_r <= '0;
      max_body_r    <= LEN_MAX_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_VIEW_LENGTH: view_length_r <= pwdata;
        REG_MAX_BODY:    max_body_r    <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_idx)
      REG_VIEW_LENGTH: prdata = view_length_r;
      REG_MAX_BODY:    prdata = {{(APB_W-LEN_W){1'b0}}, max_body_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.view_length     = view_length_r;
  assign cfg.max_body_length = max_body_r;

endmodule

FILE: design/dtw_walker.sv
`include "assert_macros.svh"

module dtw_walker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  dtw_pkg::dtw_item_t     item,
  input  dtw_pkg::dtw_cfg_t      cfg,
  output logic                   res_valid,
  output dtw_pkg::dtw_result_t   res
);
  import dtw_pkg::*;

  // Parse state.
  logic [1:0]        phase_r,  phase_nxt;
  logic [VIEW_W-1:0] rem_r,    rem_nxt;
  logic [DATA_W-1:0] tag_r,    tag_nxt;
  logic [1:0]        lol_r,    lol_nxt;
  logic [LEN_W-1:0]  acc_r,    acc_nxt;
  logic [HSIZE_W-1:0] hc_r,    hc_nxt;
  logic [LEN_W-1:0]  bbl_r,    bbl_nxt;
  logic              failed_r, failed_nxt;

  // State as seen after a possible view restart.
  logic [1:0]         eff_phase;
  logic [VIEW_W-1:0]  eff_rem;
  logic [DATA_W-1:0]  eff_tag;
  logic [1:0]         eff_lol;
  logic [LEN_W-1:0]   eff_acc;
  logic [HSIZE_W-1:0] eff_hc;
  logic [LEN_W-1:0]   eff_bbl;
  logic               eff_failed;

  logic [VIEW_W-1:0]  rem_dec;
  logic [DATA_W-1:0]  data;
  logic [6:0]         n_oct;
  logic [LEN_W-1:0]   acc_new;
  logic [1:0]         lol_new;
  logic               err_hit;
  logic [STATUS_W-1:0] err_code;
  logic [DATA_W-1:0]  err_tag;
  logic               fin_hit;
  logic [LEN_W-1:0]   fin_len;

  assign data    = item.data_byte;
  assign n_oct   = data[6:0];
  assign rem_dec = eff_rem - VIEW_W'(1);

  // A view start restarts the parse on the same byte.
  always_comb begin
    if (item.view_start) begin
      eff_phase  = PH_TAG;
      eff_rem    = cfg.view_length;
      eff_tag    = '0;
      eff_lol    = '0;
      eff_acc    = '0;
      eff_hc     = '0;
      eff_bbl    = '0;
      eff_failed = 1'b0;
    end else begin
      eff_phase  = phase_r;
      eff_rem    = rem_r;
      eff_tag    = tag_r;
      eff_lol    = lol_r;
      eff_acc    = acc_r;
      eff_hc     = hc_r;
      eff_bbl    = bbl_r;
      eff_failed = failed_r;
    end
  end

  // One byte of the walk: header decode, length check and body skip.
  always_comb begin
    phase_nxt  = eff_phase;
    rem_nxt    = eff_rem;
    tag_nxt    = eff_tag;
    lol_nxt    = eff_lol;
    acc_nxt    = eff_acc;
    hc_nxt     = eff_hc;
    bbl_nxt    = eff_bbl;
    failed_nxt = eff_failed;
    err_hit    = 1'b0;
    err_code   = ST_OK;
    err_tag    = eff_tag;
    fin_hit    = 1'b0;
    fin_len    = '0;
    acc_new    = {eff_acc[LEN_W-DATA_W-1:0], data};
    lol_new    = eff_lol - 2'd1;
    res_valid  = 1'b0;
    res        = '0;

    if (!eff_failed) begin
      if (eff_rem == '0) begin
        err_hit  = 1'b1;
        err_code = ST_PAST_END;
        err_tag  = '0;
      end else begin
        rem_nxt = rem_dec;
        case (eff_phase)
          PH_TAG: begin
            tag_nxt = data;
            hc_nxt  = HSIZE_W'(1);
            err_tag = data;
            if (eff_rem < VIEW_W'(2)) begin
              err_hit  = 1'b1;
              err_code = ST_TRUNCATED;
            end else if (data[4:0] == TAG_HIGH_FORM) begin
              err_hit  = 1'b1;
              err_code = ST_HIGH_TAG;
            end else begin
              phase_nxt = PH_LEN1;
            end
          end
          PH_LEN1: begin
            hc_nxt = HSIZE_W'(2);
            if (!data[7]) begin
              fin_hit = 1'b1;
              fin_len = LEN_W'(data);
            end else if (data == LEN_INDEFINITE) begin
              err_hit  = 1'b1;
              err_code = ST_INDEFINITE;
            end else if (data == LEN_RESERVED) begin
              err_hit  = 1'b1;
              err_code = ST_RESERVED;
            end else if (n_oct > 7'(LENGTH_OCTETS_MAX)) begin
              err_hit  = 1'b1;
              err_code = ST_TOO_MANY;
            end else if (rem_dec < VIEW_W'(n_oct)) begin
              err_hit  = 1'b1;
              err_code = ST_TRUNCATED;
            end else begin
              lol_nxt   = n_oct[1:0];
              acc_nxt   = '0;
              phase_nxt = PH_LENX;
            end
          end
          PH_LENX: begin
            if (eff_hc == HSIZE_W'(2) && data == '0) begin
              // A leading zero octet is never minimal.
              err_hit  = 1'b1;
              err_code = ST_NONMINIMAL;
            end else begin
              hc_nxt  = eff_hc + HSIZE_W'(1);
              acc_nxt = acc_new;
              lol_nxt = lol_new;
              if (lol_new == 2'd0) begin
                if (acc_new < LEN_W'(LEN_INDEFINITE)) begin
                  err_hit  = 1'b1;
                  err_code = ST_NONMINIMAL;
                end else begin
                  fin_hit = 1'b1;
                  fin_len = acc_new;
                end
              end
            end
          end
          default: begin
            if (eff_bbl != '0) begin
              bbl_nxt = eff_bbl - LEN_W'(1);
            end
            if (bbl_nxt == '0) begin
              phase_nxt = PH_TAG;
            end
          end
        endcase

        // Length limits at the end of a header.
        if (fin_hit) begin
          if (fin_len > cfg.max_body_length) begin
            err_hit  = 1'b1;
            err_code = ST_TOO_LARGE;
          end else if (VIEW_W'(fin_len) > rem_dec) begin
            err_hit  = 1'b1;
            err_code = ST_OVERRUN;
          end else begin
            bbl_nxt         = fin_len;
            phase_nxt       = (fin_len != '0) ? PH_BODY : PH_TAG;
            res_valid       = 1'b1;
            res.status      = ST_OK;
            res.element_tag = eff_tag;
            res.header_size = hc_nxt;
            res.body_length = fin_len;
          end
        end
      end

      // First error of the view: report once and go quiet.
      if (err_hit) begin
        failed_nxt      = 1'b1;
        phase_nxt       = PH_TAG;
        res_valid       = 1'b1;
        res.status      = err_code;
        res.element_tag = err_tag;
        res.header_size = '0;
        res.body_length = '0;
      end
    end
  end

  // State update, one byte per enabled cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TAG;
      rem_r    <= '0;
      tag_r    <= '0;
      lol_r    <= '0;
      acc_r    <= '0;
      hc_r     <= '0;
      bbl_r    <= '0;
      failed_r <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      rem_r    <= rem_nxt;
      tag_r    <= tag_nxt;
      lol_r    <= lol_nxt;
      acc_r    <= acc_nxt;
      hc_r     <= hc_nxt;
      bbl_r    <= bbl_nxt;
      failed_r <= failed_nxt;
    end
  end

  `ASSERT_IMP(a_failed_in_tag, clk, rst_n, failed_r, phase_r == PH_TAG)
  `ASSERT_IMP(a_body_nonzero, clk, rst_n, phase_r == PH_BODY, bbl_r != '0)
  `ASSERT_IMP(a_ok_hsize, clk, rst_n, res_valid && res.status == ST_OK, res.header_size >= HSIZE_W'(2) && res.header_size <= HSIZE_W'(5))

endmodule

FILE: design/der_tlv_header_walker_core.sv
// DER tag-length-value header walker.
// in_ch carries one byte of a view per beat; view_start on a beat marks the
// first byte of a new view, reloads the byte budget from view_length and
// clears any earlier error. out_ch carries zero or one result per input beat:
// a completed header (tag, header size, body length) or the first error of
// the view, after which bytes are dropped silently until the next view start.
// view_length and max_body_length sit on the APB-style cfg_ port at byte
// addresses 0 and 4; write them only while the walker is idle.
// Throughput is one byte per cycle while the receiver does not stall: each byte
// passes an input register, combinational decode against the parse state, and
// a result register. A result is presented from the result register once its
// byte has stepped the walker.
// When the receiver stalls, the result register holds and the input register
// fills; in_ch.ready drops only once both are occupied.
// Synchronous reset empties both registers, clears the parse state (so any
// byte before the first view start reports past end) and loads the register
// defaults: view_length 0, max_body_length all ones.
module der_tlv_header_walker_core (
  input  logic                        clk,
  input  logic                        rst_n,
  dtw_in_if.sink                      in_ch,
  dtw_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dtw_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [dtw_pkg::APB_W-1:0]   cfg_pwdata,
  output logic [dtw_pkg::APB_W-1:0]   cfg_prdata,
  output logic                        cfg_pready
);
  import dtw_pkg::*;

  dtw_cfg_t    cfg;
  dtw_item_t   item_r;
  logic        in_valid_r;
  dtw_result_t res;
  logic        res_valid;
  dtw_result_t out_res_r;
  logic        out_valid_r;
  logic        out_free;
  logic        step_en;

  dtw_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Handshake: the held byte moves on whenever the result slot frees up.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign step_en     = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || step_en;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.data_byte  <= in_ch.data_byte;
      item_r.view_start <= in_ch.view_start;
    end
  end

  dtw_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.element_tag = out_res_r.element_tag;
  assign out_ch.header_size = out_res_r.header_size;
  assign out_ch.body_length = out_res_r.body_length;

  `ASSERT_NXT(a_result_lands, clk, rst_n, step_en && res_valid, out_valid_r)
  `ASSERT_NXT(a_result_holds, clk, rst_n, out_valid_r && !out_ch.ready, out_valid_r)
  `ASSERT_IMP(a_in_full, clk, rst_n, !in_ch.ready, in_valid_r && out_valid_r)

endmodule

FILE: sim/dtw_walk_checker.sv
`timescale 1ns / 1ps

// Watches the byte and result channels of the TLV header walker, keeps its own
// copy of the parse state and the register values, and compares every result
// beat with the oldest one still due.
module dtw_walk_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  dtw_in_if                          in_mon,
  dtw_out_if                         out_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [dtw_pkg::ADDR_W-1:0] paddr,
  input  logic [dtw_pkg::APB_W-1:0]  pwdata,
  output int                         mismatch_count,
  output int                         results_due,
  output int                         results_seen,
  output int                         headers_seen
);
  import dtw_pkg::*;

  // Register copies, updated from the write strobes on the APB bus.
  logic [VIEW_W-1:0]  view_len_cfg;
  logic [LEN_W-1:0]   body_limit_cfg;

  // Parse state of the walker.
  logic [1:0]         walk_phase;
  logic [VIEW_W-1:0]  view_left;
  logic [DATA_W-1:0]  cur_tag;
  logic [1:0]         len_octets_left;
  logic [LEN_W-1:0]   len_acc;
  logic [HSIZE_W-1:0] hdr_bytes;
  logic [LEN_W-1:0]   body_left;
  logic               view_failed;

  dtw_result_t        due_results[$];
  int                 n_bad;
  int                 n_seen;
  int                 n_headers;

  // An error ends the view: later bytes are dropped until the next view start.
  function automatic dtw_result_t view_error(input logic [STATUS_W-1:0] code,
                                             input logic [DATA_W-1:0]   tag);
    dtw_result_t r;
    view_failed   = 1'b1;
    walk_phase    = PH_TAG;
    r.status      = code;
    r.element_tag = tag;
    r.header_size = '0;
    r.body_length = '0;
    return r;
  endfunction

  // The length is complete: check it against the limit and the rest of the view.
  function automatic dtw_result_t close_header(input logic [LEN_W-1:0] len);
    dtw_result_t r;
    if (len > body_limit_cfg) return view_error(ST_TOO_LARGE, cur_tag);
    if (VIEW_W'(len) > view_left) return view_error(ST_OVERRUN, cur_tag);
    body_left     = len;
    walk_phase    = (len != '0) ? PH_BODY : PH_TAG;
    r.status      = ST_OK;
    r.element_tag = cur_tag;
    r.header_size = hdr_bytes;
    r.body_length = len;
    return r;
  endfunction

  // Advances the parse by one byte; returns 1 when the byte yields a result.
  function automatic bit walk_byte(input logic [DATA_W-1:0] b, input logic restart,
                                   output dtw_result_t r);
    logic [VIEW_W-1:0] avail;
    logic [6:0]        n_octets;
    r = '0;
    if (restart) begin
      walk_phase      = PH_TAG;
      view_left       = view_len_cfg;
      cur_tag         = '0;
      len_octets_left = '0;
      len_acc         = '0;
      hdr_bytes       = '0;
      body_left       = '0;
      view_failed     = 1'b0;
    end
    if (view_failed) return 1'b0;
    if (view_left == '0) begin
      r = view_error(ST_PAST_END, '0);
      return 1'b1;
    end
    avail     = view_left;
    view_left = view_left - 1'b1;
    case (walk_phase)
      PH_TAG: begin
        cur_tag   = b;
        hdr_bytes = 3'd1;
        // A tag needs at least one more byte for its length.
        if (avail < 2) begin
          r = view_error(ST_TRUNCATED, b);
          return 1'b1;
        end
        if (b[4:0] == TAG_HIGH_FORM) begin
          r = view_error(ST_HIGH_TAG, b);
          return 1'b1;
        end
        walk_phase = PH_LEN1;
        return 1'b0;
      end
      PH_LEN1: begin
        hdr_bytes = 3'd2;
        if (b < LEN_INDEFINITE) begin
          r = close_header(LEN_W'(b));
          return 1'b1;
        end
        if (b == LEN_INDEFINITE) begin
          r = view_error(ST_INDEFINITE, cur_tag);
          return 1'b1;
        end
        if (b == LEN_RESERVED) begin
          r = view_error(ST_RESERVED, cur_tag);
          return 1'b1;
        end
        n_octets = b[6:0];
        if (n_octets > 7'(LENGTH_OCTETS_MAX)) begin
          r = view_error(ST_TOO_MANY, cur_tag);
          return 1'b1;
        end
        // The length octets themselves must fit in the view.
        if (view_left < VIEW_W'(n_octets)) begin
          r = view_error(ST_TRUNCATED, cur_tag);
          return 1'b1;
        end
        len_octets_left = n_octets[1:0];
        len_acc         = '0;
        walk_phase      = PH_LENX;
        return 1'b0;
      end
      PH_LENX: begin
        // A leading zero octet is never minimal.
        if (hdr_bytes == 3'd2 && b == 8'h00) begin
          r = view_error(ST_NONMINIMAL, cur_tag);
          return 1'b1;
        end
        hdr_bytes       = hdr_bytes + 1'b1;
        len_acc         = {len_acc[LEN_W-9:0], b};
        len_octets_left = len_octets_left - 1'b1;
        if (len_octets_left == '0) begin
          // Lengths below 128 must use the short form.
          if (len_acc < 24'h80) begin
            r = view_error(ST_NONMINIMAL, cur_tag);
            return 1'b1;
          end
          r = close_header(len_acc);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (body_left != '0) body_left = body_left - 1'b1;
        if (body_left == '0) walk_phase = PH_TAG;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report(input string what, input dtw_result_t want, input dtw_result_t got);
    n_bad++;
    if (n_bad <= 10) begin
      $display("[%0t] %s: expected status %0d tag %02h size %0d length %0d,",
               $time, what, want.status, want.element_tag, want.header_size,
               want.body_length,
               " got status %0d tag %02h size %0d length %0d",
               got.status, got.element_tag, got.header_size, got.body_length);
    end
  endtask

  always @(posedge clk) begin : watch
    dtw_result_t want;
    dtw_result_t got;
    string       which;
    if (!rst_n) begin
      view_len_cfg    = '0;
      body_limit_cfg  = LEN_MAX_RESET;
      walk_phase      = PH_TAG;
      view_left       = '0;
      cur_tag         = '0;
      len_octets_left = '0;
      len_acc         = '0;
      hdr_bytes       = '0;
      body_left       = '0;
      view_failed     = 1'b0;
      n_bad           = 0;
      n_seen          = 0;
      n_headers       = 0;
      due_results.delete();
    end else begin
      // Register writes land at the access phase.
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_VIEW_LENGTH) view_len_cfg = pwdata[VIEW_W-1:0];
        else body_limit_cfg = pwdata[LEN_W-1:0];
      end

      // A result beat always belongs to a byte accepted earlier, so it is
      // checked before this edge's byte is predicted.
      if (out_mon.valid && out_mon.ready) begin
        got.status      = out_mon.status;
        got.element_tag = out_mon.element_tag;
        got.header_size = out_mon.header_size;
        got.body_length = out_mon.body_length;
        n_seen++;
        if (got.status == ST_OK) n_headers++;
        if (due_results.size() == 0) begin
          report("result with nothing due", '0, got);
        end else begin
          want  = due_results.pop_front();
          which = "";
          if (got.status != want.status) which = {which, " status"};
          if (got.element_tag != want.element_tag) which = {which, " tag"};
          if (got.header_size != want.header_size) which = {which, " size"};
          if (got.body_length != want.body_length) which = {which, " length"};
          if (which != "") report({"mismatch in", which}, want, got);
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        if (walk_byte(in_mon.data_byte, in_mon.view_start, want)) due_results.push_back(want);
      end
    end
    mismatch_count <= n_bad;
    results_due    <= due_results.size();
    results_seen   <= n_seen;
    headers_seen   <= n_headers;
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import dtw_pkg::*;

  // A stall of this many cycles with no beat on either channel is a hang; the
  // longest legal quiet spell is two drain pauses plus two register writes.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RANDOM_BYTES   = 860;

  localparam logic [ADDR_W-1:0] ADDR_VIEW_LENGTH = {REG_VIEW_LENGTH, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_MAX_BODY    = {REG_MAX_BODY, 2'b00};
  localparam logic [VIEW_W-1:0] VIEW_ENDLESS     = '1;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  dtw_in_if  in_ch ();
  dtw_out_if out_ch ();

  int                mismatch_count;
  int                results_due;
  int                results_seen;
  int                headers_seen;
  int                bytes_sent   = 0;
  int                views_sent   = 0;
  int                stall_cycles = 0;
  bit                calm         = 1'b0;
  logic [VIEW_W-1:0] view_len_written = '0;

  der_tlv_header_walker_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (psel),
    .cfg_penable (penable),
    .cfg_pwrite  (pwrite),
    .cfg_paddr   (paddr),
    .cfg_pwdata  (pwdata),
    .cfg_prdata  (prdata),
    .cfg_pready  (pready)
  );

  dtw_walk_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .results_due    (results_due),
    .results_seen   (results_seen),
    .headers_seen   (headers_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls about a quarter of the time, except in the calm stretch.
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready)) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d results still due",
                 stall_cycles, results_due);
        $display("*** FAILED ***");
        $finish;
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  // Offers one byte, with random gaps in front of it, and waits for its beat.
  task automatic send_byte(input logic [DATA_W-1:0] b, input logic restart);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.view_start <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Holds the sender until every result is back and the pipeline has drained.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [APB_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one view; the length register is only rewritten when it changes, so
  // views of equal length follow each other without a pause.
  task automatic run_view(input logic [VIEW_W-1:0] vlen, input logic [DATA_W-1:0] bytes_q[$]);
    if (vlen != view_len_written) begin
      wait_idle();
      reg_write(ADDR_VIEW_LENGTH, vlen);
      view_len_written = vlen;
    end
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == 0);
    views_sent++;
  endtask

  // Any identifier octet in low tag number form.
  function automatic logic [DATA_W-1:0] good_tag();
    logic [DATA_W-1:0] t;
    t = 8'($urandom_range(0, 255));
    if (t[4:0] == TAG_HIGH_FORM) t[0] = 1'b0;
    return t;
  endfunction

  // Appends a header with a minimal length encoding and, if asked, its body.
  function automatic void add_element(ref logic [DATA_W-1:0] q[$],
                                      input logic [DATA_W-1:0] tag,
                                      input int unsigned len, input bit with_body);
    int unsigned n_octets;
    n_octets = (len < 128) ? 0 : (len < 256) ? 1 : (len < 65536) ? 2 : 3;
    q.push_back(tag);
    if (n_octets == 0) begin
      q.push_back(8'(len));
    end else begin
      q.push_back(8'h80 | 8'(n_octets));
      for (int i = n_octets; i > 0; i--) q.push_back(8'(len >> (8 * (i - 1))));
    end
    if (with_body) repeat (len) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  initial begin
    logic [DATA_W-1:0] q[$];
    logic [VIEW_W-1:0] vlen;
    int unsigned       pick;
    int unsigned       len;
    int unsigned       n;
    int                directed_bytes;
    int                progress;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= '0;
    in_ch.view_start <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Before any view start the byte budget is zero.
    send_byte(8'h00, 1'b0);
    // An empty view, then a view too short for even a tag and a length.
    q = {8'hFF};
    run_view(32'd0, q);
    q = {8'h02};
    run_view(32'd1, q);
    // Header errors in an endless view, restarting after each one; the byte
    // after the high tag is dropped.
    q = {8'h1F, 8'h05};
    run_view(VIEW_ENDLESS, q);
    q = {8'h30, LEN_INDEFINITE};
    run_view(VIEW_ENDLESS, q);
    q = {8'h02, LEN_RESERVED};
    run_view(VIEW_ENDLESS, q);
    q = {8'h04, 8'h84};
    run_view(VIEW_ENDLESS, q);
    q = {8'h04, 8'h82, 8'h00};
    run_view(VIEW_ENDLESS, q);
    q = {8'h04, 8'h81, 8'h7F};
    run_view(VIEW_ENDLESS, q);
    // Long-form length octets that do not fit in the view.
    q = {8'h04, 8'h82};
    run_view(32'd3, q);
    // The largest length against a view with one byte left.
    q = {8'h05, 8'h83, 8'hFF, 8'hFF, 8'hFF};
    run_view(32'd6, q);
    // With a zero limit only an empty body is accepted.
    wait_idle();
    reg_write(ADDR_MAX_BODY, '0);
    q = {8'h05, 8'h00, 8'hE0, 8'h01};
    run_view(VIEW_ENDLESS, q);
    wait_idle();
    reg_write(ADDR_MAX_BODY, APB_W'(LEN_MAX_RESET));
    directed_bytes = bytes_sent;

    // Random views: mostly well-formed element chains, the rest broken headers
    // and plain noise.
    while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
      progress = bytes_sent - directed_bytes;
      calm     = (progress >= 300 && progress < 450);

      if ($urandom_range(0, 99) < 8) begin
        pick = $urandom_range(0, 99);
        wait_idle();
        if (pick < 55) reg_write(ADDR_MAX_BODY, APB_W'(LEN_MAX_RESET));
        else if (pick < 65) reg_write(ADDR_MAX_BODY, '0);
        else if (pick < 85) reg_write(ADDR_MAX_BODY, $urandom_range(0, 40));
        else reg_write(ADDR_MAX_BODY, $urandom_range(0, 32'hFFFFFF));
      end

      q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        repeat ($urandom_range(1, 4)) begin
          n = $urandom_range(0, 99);
          if (n < 4) len = $urandom_range(128, 200);
          else if (n < 5) len = $urandom_range(256, 300);
          else len = $urandom_range(0, 24);
          add_element(q, good_tag(), len, 1'b1);
        end
        vlen = q.size();
        case ($urandom_range(0, 9))
          0: vlen = q.size() - $urandom_range(1, 2);
          1: repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
          2: vlen = VIEW_ENDLESS;
          // Cut the view short; the next view start lands mid-element.
          3: begin
            n = $urandom_range(1, q.size() - 1);
            while (q.size() > n) void'(q.pop_back());
          end
          default: ;
        endcase
      end else if (pick < 85) begin
        n = $urandom_range(0, 9);
        if (n < 3) begin
          // A sound header of any length whose body is never sent.
          add_element(q, good_tag(), $urandom_range(0, 32'hFFFFFF), 1'b0);
        end else begin
          q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : good_tag());
          if (n < 5) begin
            q.push_back(8'($urandom_range(0, 255)));
          end else begin
            len = (n == 9) ? $urandom_range(4, 7) : $urandom_range(1, 3);
            q.push_back(8'h80 | 8'(len));
            q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
            repeat (len - 1) q.push_back(8'($urandom_range(0, 255)));
          end
        end
        repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
          0: vlen = $urandom_range(0, 12);
          1: vlen = q.size() + $urandom_range(0, 2);
          2: vlen = VIEW_ENDLESS;
          default: vlen = $urandom();
        endcase
      end else begin
        repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(0, 255)));
        vlen = ($urandom_range(0, 1) == 0) ? VIEW_W'($urandom_range(0, 10)) : VIEW_ENDLESS;
      end
      run_view(vlen, q);
    end
    calm = 1'b0;

    wait_idle();
    $display("Walked %0d bytes in %0d views; %0d results checked, %0d of them good headers.",
             bytes_sent, views_sent, results_seen, headers_seen);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
